// ----- hdl/okl_pkg.sv -----
// ============================================================================
// okl_pkg
// Shared types and constants for the ordered key list table: operation and
// status codes, the probe word that travels down the cell chain, and the
// control word that the controller broadcasts to every cell.
// ============================================================================
package okl_pkg;

    localparam int NODE_CAPACITY = 64;
    localparam int COUNT_W       = $clog2(NODE_CAPACITY + 1);
    localparam int KEY_W         = 32;
    localparam int PAYLOAD_W     = 32;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic                 valid;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic                 valid;
        logic                 remove;
        logic                 found;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } probe_t;

    typedef struct packed {
        logic                 append_en;
        logic                 shift_en;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } cell_ctl_t;

endpackage

// ----- hdl/okl_cell.sv -----
// ============================================================================
// okl_cell
// One slot of the ordered list. It holds one entry, checks the passing probe
// word against its key, marks itself for compaction on a remove, and takes
// over its right neighbor's entry when the list closes a gap.
// ============================================================================
module okl_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  okl_pkg::cell_ctl_t ctl,
    input  logic              prev_valid,
    input  okl_pkg::entry_t   next_entry,
    input  okl_pkg::probe_t   probe_in,
    output okl_pkg::entry_t   entry,
    output okl_pkg::probe_t   probe_out
);
    import okl_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [KEY_W-1:0]     key_reg;
    logic [KEY_W-1:0]     key_next;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic [PAYLOAD_W-1:0] payload_next;
    logic                 mark_reg;
    logic                 mark_next;
    probe_t               probe_reg;
    probe_t               probe_next;
    logic                 match;

    assign match = probe_in.valid && valid_reg && (key_reg == probe_in.key);

    always_comb
    begin
        valid_next   = valid_reg;
        key_next     = key_reg;
        payload_next = payload_reg;
        mark_next    = mark_reg;
        if (ctl.shift_en)
        begin
            if (mark_reg)
            begin
                valid_next   = next_entry.valid;
                key_next     = next_entry.key;
                payload_next = next_entry.payload;
            end
            mark_next = 1'b0;
        end
        else
        begin
            if (ctl.append_en && !valid_reg && prev_valid)
            begin
                valid_next   = 1'b1;
                key_next     = ctl.key;
                payload_next = ctl.payload;
            end
            if (probe_in.valid && probe_in.remove && (probe_in.found || match))
            begin
                mark_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        probe_next = probe_in;
        if (match && !probe_in.found)
        begin
            probe_next.found = 1'b1;
            if (!probe_in.remove)
            begin
                probe_next.payload = payload_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            mark_reg  <= 1'b0;
            probe_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign entry.valid   = valid_reg;
    assign entry.key     = key_reg;
    assign entry.payload = payload_reg;
    assign probe_out     = probe_reg;

endmodule

// ----- hdl/okl_ctrl.sv -----
// ============================================================================
// okl_ctrl
// Request sequencer for the ordered key list table. It takes one word at a
// time, launches probes into the cell chain, keeps the entry count and holds
// the result word in an output register until it is taken.
// ============================================================================
module okl_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic signed [okl_pkg::KEY_W-1:0] key,
    input  logic [okl_pkg::PAYLOAD_W-1:0] payload,
    input  logic                          table_full,
    input  okl_pkg::probe_t               last_probe,
    output okl_pkg::probe_t               launch_probe,
    output okl_pkg::cell_ctl_t            cell_ctl,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [okl_pkg::PAYLOAD_W-1:0] found_payload,
    output logic [okl_pkg::COUNT_W-1:0]   entry_count,
    output logic                          is_empty
);
    import okl_pkg::*;

    ctrl_state_t          state_reg;
    ctrl_state_t          state_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    status_t              res_status_reg;
    status_t              res_status_next;
    logic [PAYLOAD_W-1:0] res_payload_reg;
    logic [PAYLOAD_W-1:0] res_payload_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    status_t              out_status_reg;
    logic [PAYLOAD_W-1:0] out_payload_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic                 out_empty_reg;

    logic                 accept;
    logic                 out_free;
    logic                 load_out;
    logic                 is_append;
    logic                 is_walk_op;

    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign is_append  = (opcode == OP_APPEND);
    assign is_walk_op = (opcode == OP_SEARCH) || (opcode == OP_REMOVE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = is_walk_op ? S_WALK : S_DONE;
                end
            end
            S_WALK:
            begin
                if (last_probe.valid)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall             = 1'b1;
        load_out             = 1'b0;
        cell_ctl.append_en   = 1'b0;
        cell_ctl.shift_en    = 1'b0;
        cell_ctl.key         = key;
        cell_ctl.payload     = payload;
        launch_probe.valid   = 1'b0;
        launch_probe.remove  = (opcode == OP_REMOVE);
        launch_probe.found   = 1'b0;
        launch_probe.key     = key;
        launch_probe.payload = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall           = 1'b0;
                cell_ctl.append_en = in_valid && is_append && !table_full;
                launch_probe.valid = in_valid && is_walk_op;
            end
            S_WALK:
            begin
                cell_ctl.shift_en = last_probe.valid && last_probe.remove
                                    && last_probe.found;
            end
            S_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        count_next       = count_reg;
        res_status_next  = res_status_reg;
        res_payload_next = res_payload_reg;
        if (cell_ctl.append_en)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (cell_ctl.shift_en)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
        if (accept)
        begin
            res_payload_next = '0;
            if (is_append)
            begin
                res_status_next = table_full ? ST_FULL : ST_DONE;
            end
            else
            begin
                res_status_next = ST_NOT_FOUND;
            end
        end
        else if ((state_reg == S_WALK) && last_probe.valid)
        begin
            res_status_next  = last_probe.found ? ST_DONE : ST_NOT_FOUND;
            res_payload_next = last_probe.payload;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg  <= res_status_next;
        res_payload_reg <= res_payload_next;
        if (load_out)
        begin
            out_status_reg  <= res_status_reg;
            out_payload_reg <= res_payload_reg;
            out_count_reg   <= count_reg;
            out_empty_reg   <= (count_reg == '0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign found_payload = out_payload_reg;
    assign entry_count   = out_count_reg;
    assign is_empty      = out_empty_reg;

endmodule

// ----- hdl/ordered_key_list_table.sv -----
// Append and unused opcodes go from idle straight to the done state once the word is accepted.
// Search and remove pass through the walk state first, until the probe leaves the last cell.
// The probe passes one cell of the 64-cell chain per cycle.
// One request is in work at a time; the next word is taken in the cycle after the result loads.
// Reset (rst_n, asynchronous, active low) empties the list and the output register at once.
// ============================================================================
// ordered_key_list_table
// Bounded, insertion-ordered table of key and payload entries held in a
// chain of cells. Appends fill the first free cell, searches and removes
// send a probe down the chain, and a remove closes the gap by shifting every later entry one cell toward the head.
// ============================================================================
module ordered_key_list_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       opcode,
    input  logic signed [okl_pkg::KEY_W-1:0] key,
    input  logic [okl_pkg::PAYLOAD_W-1:0]    payload,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       status,
    output logic [okl_pkg::PAYLOAD_W-1:0]    found_payload,
    output logic [okl_pkg::COUNT_W-1:0]      entry_count,
    output logic                             is_empty
);
    import okl_pkg::*;

    cell_ctl_t cell_ctl;
    probe_t    launch_probe;
    entry_t    cell_entry [NODE_CAPACITY];
    probe_t    cell_probe [NODE_CAPACITY];

    okl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .key          (key),
        .payload      (payload),
        .table_full   (cell_entry[NODE_CAPACITY-1].valid),
        .last_probe   (cell_probe[NODE_CAPACITY-1]),
        .launch_probe (launch_probe),
        .cell_ctl     (cell_ctl),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .found_payload(found_payload),
        .entry_count  (entry_count),
        .is_empty     (is_empty)
    );

    for (genvar i = 0; i < NODE_CAPACITY; i++)
    begin : g_cell
        logic   prev_valid;
        entry_t next_entry;
        probe_t probe_in;

        if (i == 0)
        begin : g_first
            assign prev_valid = 1'b1;
            assign probe_in   = launch_probe;
        end
        else
        begin : g_rest
            assign prev_valid = cell_entry[i-1].valid;
            assign probe_in   = cell_probe[i-1];
        end

        if (i == NODE_CAPACITY - 1)
        begin : g_last
            assign next_entry = '0;
        end
        else
        begin : g_inner
            assign next_entry = cell_entry[i+1];
        end

        okl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cell_ctl),
            .prev_valid(prev_valid),
            .next_entry(next_entry),
            .probe_in  (probe_in),
            .entry     (cell_entry[i]),
            .probe_out (cell_probe[i])
        );
    end

endmodule

// ----- hdl/okl_checker.sv -----
// ============================================================================
// okl_checker
// Port-level checks for the ordered key list table: consistency of the
// result word fields and stability of a stalled result word.
// ============================================================================
module okl_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [1:0]                       status,
    input logic [okl_pkg::PAYLOAD_W-1:0]    found_payload,
    input logic [okl_pkg::COUNT_W-1:0]      entry_count,
    input logic                             is_empty
);
    import okl_pkg::*;

    a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (entry_count == '0)))
        else $error("is_empty disagrees with entry_count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= COUNT_W'(NODE_CAPACITY)))
        else $error("entry_count above capacity");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_DONE || status == ST_NOT_FOUND
                       || status == ST_FULL))
        else $error("status carries an unused code");

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_DONE)) |-> (found_payload == '0))
        else $error("found_payload nonzero on a failed request");

    a_stalled_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status)
                                      && $stable(found_payload)
                                      && $stable(entry_count)))
        else $error("stalled result word changed");

endmodule

bind ordered_key_list_table okl_checker u_okl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .found_payload(found_payload),
    .entry_count  (entry_count),
    .is_empty     (is_empty)
);
